>>> sv/pressure_temperature_compensation_defines.svh
// Assertion macros for the pressure/temperature compensation block.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ptc_pkg.sv
// Shared types, constants and coefficient unpacking for the compensation pipeline.
`default_nettype none

package ptc_pkg;

   localparam int FRACTION_BITS = 4;
   localparam int PIPE_DEPTH    = 10;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_CAL_WORD_ONE   = 4'd0;
   localparam csr_idx_type CSR_CAL_WORD_TWO   = 4'd1;
   localparam csr_idx_type CSR_CAL_WORD_THREE = 4'd2;
   localparam csr_idx_type CSR_CAL_WORD_FOUR  = 4'd3;

   typedef struct packed {
      logic [14:0] c1;
      logic [11:0] c2;
      logic [9:0]  c3;
      logic [9:0]  c4;
      logic [10:0] c5;
      logic [5:0]  c6;
   } coef_type;

   localparam logic [16:0]        DT_BIAS       = 17'd20224;
   localparam logic [15:0]        SENS_BIAS     = 16'd24576;
   localparam logic signed [16:0] D1_BIAS       = 17'sd7168;
   localparam logic signed [10:0] C4_BIAS       = 11'sd512;
   localparam logic [6:0]         C6_TEMP_BIAS  = 7'd50;
   localparam logic [6:0]         C6_CORR_BIAS  = 7'd24;
   localparam logic [9:0]         COLD_GAIN     = 10'd11;
   localparam logic [9:0]         HOT_GAIN      = 10'd3;
   // temperature thresholds 20.0 C and 45.0 C, scaled by 2^10
   localparam logic signed [24:0] TS_COLD       = 25'sd204800;
   localparam logic signed [24:0] TS_HOT        = 25'sd460800;
   // 2500 and 3500 tenths of mbar, scaled by 2^29
   localparam logic signed [46:0] PS_BASE       = 47'sd1342177280000;
   localparam logic signed [46:0] PS_REF        = 47'sd1879048192000;

   localparam int TEMP_SHIFT = 40 - FRACTION_BITS;
   localparam int PRES_SHIFT = 83 - FRACTION_BITS;

   localparam longint TEMP_MIN = -32768;
   localparam longint TEMP_MAX = 32767;
   localparam longint PRES_MIN = -262144;
   localparam longint PRES_MAX = 262143;

   function automatic coef_type unpack_coef(input logic [15:0] w1, input logic [15:0] w2,
                                            input logic [15:0] w3, input logic [15:0] w4);
      coef_type c;
      c.c1 = w1[15:1];
      c.c2 = {w3[5:0], w4[5:0]};
      c.c3 = w4[15:6];
      c.c4 = w3[15:6];
      c.c5 = {w1[0], w2[15:6]};
      c.c6 = w2[5:0];
      return c;
   endfunction

endpackage

`default_nettype wire

>>> sv/pressure_temperature_compensation.sv
// Barometric sensor compensation: ten-stage pipeline from raw conversions to results.
//
// Usage:
//   Calibration words are written through the csr_ port (index 0..3, 16-bit data);
//   csr_ready is always high and writes to other indexes are dropped. Write them
//   while no conversion is in flight.
//   A conversion pair (req_raw_pressure, req_raw_temperature) is taken on each edge
//   with start high and busy low. busy stays low, so one pair enters every cycle.
//   Each beat comes out of the last stage with rsp_valid high for one cycle, carrying
//   temperature (0.1 C), pressure (0.1 mbar), both with 4 fraction bits, and
//   rsp_clipped when either value was saturated.
//   The pipeline has 10 register stages, the last four spent
//   on the 56 x 47 bit second-order pressure product (four partial products, two
//   adder levels) and the final subtract and saturate.
//   The receiver cannot stall; results are never held.
//   Reset clears the calibration words and all valid bits; beats in flight are lost.
`default_nettype none

`include "pressure_temperature_compensation_defines.svh"

module pressure_temperature_compensation (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [15:0]                      req_raw_pressure,
   input  wire logic [15:0]                      req_raw_temperature,
   output logic                                  rsp_valid,
   output logic signed [15:0]                    rsp_temperature_out,
   output logic signed [18:0]                    rsp_pressure_out,
   output logic                                  rsp_clipped,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ptc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [15:0]                      csr_wdata
);

   // ---------------- calibration registers ----------------
   logic [15:0] cal_one_ff, cal_two_ff, cal_three_ff, cal_four_ff;
   ptc_pkg::coef_type coef;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_one_ff   <= '0;
         cal_two_ff   <= '0;
         cal_three_ff <= '0;
         cal_four_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ptc_pkg::CSR_CAL_WORD_ONE:   cal_one_ff   <= csr_wdata;
            ptc_pkg::CSR_CAL_WORD_TWO:   cal_two_ff   <= csr_wdata;
            ptc_pkg::CSR_CAL_WORD_THREE: cal_three_ff <= csr_wdata;
            ptc_pkg::CSR_CAL_WORD_FOUR:  cal_four_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign coef = ptc_pkg::unpack_coef(cal_one_ff, cal_two_ff, cal_three_ff, cal_four_ff);

   // ---------------- valid chain ----------------
   logic [ptc_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;

   assign vld_in = {vld_ff[ptc_pkg::PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: dt, D1 offset ----------------
   logic [16:0]        dt_bias;
   logic signed [17:0] dt_wide;
   logic signed [16:0] s1_dt_ff, s1_dt_in, s1_d1m_ff, s1_d1m_in;

   assign dt_bias   = 17'({coef.c5, 3'b000}) + ptc_pkg::DT_BIAS;
   assign dt_wide   = $signed({2'b00, req_raw_temperature}) - $signed({1'b0, dt_bias});
   assign s1_dt_in  = dt_wide[16:0];
   assign s1_d1m_in = $signed({1'b0, req_raw_pressure}) - ptc_pkg::D1_BIAS;

   // ---------------- stage 2: offset, sensitivity, first-order temperature ----------------
   logic signed [10:0] c4m;
   logic signed [27:0] offs_mul, sens_mul;
   logic [15:0]        sens_base;
   logic [6:0]         c6t;
   logic signed [24:0] ts_mul, ts_sum;
   logic signed [27:0] s2_offs_ff, s2_offs_in, s2_sens_ff, s2_sens_in;
   logic signed [23:0] s2_ts_ff, s2_ts_in;
   logic signed [16:0] s2_d1m_ff;

   assign c4m        = $signed({1'b0, coef.c4}) - ptc_pkg::C4_BIAS;
   assign offs_mul   = c4m * s1_dt_ff;
   assign s2_offs_in = $signed({2'b00, coef.c2, 14'd0}) + offs_mul;
   assign sens_mul   = $signed({1'b0, coef.c3}) * s1_dt_ff;
   assign sens_base  = ptc_pkg::SENS_BIAS + 16'(coef.c1);
   assign s2_sens_in = $signed({2'b00, sens_base, 10'd0}) + sens_mul;
   assign c6t        = 7'(coef.c6) + ptc_pkg::C6_TEMP_BIAS;
   assign ts_mul     = $signed({1'b0, c6t}) * s1_dt_ff;
   assign ts_sum     = ts_mul + ptc_pkg::TS_COLD;
   assign s2_ts_in   = ts_sum[23:0];

   // ---------------- stage 3: sens * (D1 - 7168), correction distance ----------------
   logic               cold, hot;
   logic signed [24:0] mag_wide;
   logic signed [44:0] s3_xprod_ff, s3_xprod_in;
   logic signed [27:0] s3_offs_ff;
   logic signed [23:0] s3_ts_ff;
   logic [22:0]        s3_mag_ff, s3_mag_in;
   logic               s3_cold_ff, s3_hot_ff;

   assign s3_xprod_in = s2_sens_ff * s2_d1m_ff;
   assign cold        = s2_ts_ff < ptc_pkg::TS_COLD;
   assign hot         = s2_ts_ff > ptc_pkg::TS_HOT;
   assign mag_wide    = cold ? (ptc_pkg::TS_COLD - s2_ts_ff) : (s2_ts_ff - ptc_pkg::TS_HOT);
   assign s3_mag_in   = mag_wide[22:0];

   // ---------------- stage 4: x, squared distance ----------------
   logic signed [39:0] offs_scaled;
   logic signed [44:0] xs_wide;
   logic signed [43:0] s4_xs_ff, s4_xs_in;
   logic [45:0]        s4_sq_ff, s4_sq_in;
   logic signed [23:0] s4_ts_ff;
   logic               s4_cold_ff, s4_hot_ff;

   assign offs_scaled = {s3_offs_ff, 12'd0};
   assign xs_wide     = s3_xprod_ff - offs_scaled;
   assign s4_xs_in    = xs_wide[43:0];
   assign s4_sq_in    = s3_mag_ff * s3_mag_ff;

   // ---------------- stage 5: pressure, t2 numerator ----------------
   logic signed [46:0] xs_ext;
   logic [6:0]         c6c;
   logic [9:0]         corr_k;
   logic signed [46:0] s5_ps_ff, s5_ps_in;
   logic [55:0]        s5_t2_ff, s5_t2_in;
   logic signed [23:0] s5_ts_ff;
   logic               s5_cold_ff;

   assign xs_ext   = s4_xs_ff;
   assign s5_ps_in = (xs_ext <<< 3) + (xs_ext <<< 1) + ptc_pkg::PS_BASE;
   assign c6c      = 7'(coef.c6) + ptc_pkg::C6_CORR_BIAS;

   always_comb begin
      priority if (s4_cold_ff) begin
         corr_k = c6c * ptc_pkg::COLD_GAIN;
      end else if (s4_hot_ff) begin
         corr_k = c6c * ptc_pkg::HOT_GAIN;
      end else begin
         corr_k = '0;
      end
   end

   assign s5_t2_in = corr_k * s4_sq_ff;

   // ---------------- stage 6: temperature result, p2 operands ----------------
   logic signed [56:0] tnum, tq;
   logic [57:0]        t2x3;
   logic signed [15:0] s6_temp_ff, s6_temp_in;
   logic               s6_tclip_ff, s6_tclip_in;
   logic signed [46:0] s6_b_ff, s6_b_in, s6_ps_ff;
   logic [55:0]        s6_acoef_ff, s6_acoef_in;

   assign tnum = $signed({s5_ts_ff, 30'd0}) - $signed({1'b0, s5_t2_ff});
   assign tq   = tnum >>> ptc_pkg::TEMP_SHIFT;

   always_comb begin
      priority if (tq < ptc_pkg::TEMP_MIN) begin
         s6_temp_in  = 16'(ptc_pkg::TEMP_MIN);
         s6_tclip_in = 1'b1;
      end else if (tq > ptc_pkg::TEMP_MAX) begin
         s6_temp_in  = 16'(ptc_pkg::TEMP_MAX);
         s6_tclip_in = 1'b1;
      end else begin
         s6_temp_in  = tq[15:0];
         s6_tclip_in = 1'b0;
      end
   end

   assign s6_b_in     = s5_ps_ff - ptc_pkg::PS_REF;
   // 3 * t2 stays below 2^56 over the whole input range
   assign t2x3        = {2'b00, s5_t2_ff} + {1'b0, s5_t2_ff, 1'b0};
   assign s6_acoef_in = s5_cold_ff ? t2x3[55:0] : '0;

   // ---------------- stage 7: partial products of acoef * b ----------------
   logic [27:0]        a_lo, a_hi;
   logic [23:0]        b_lo;
   logic [22:0]        b_hi;
   logic [51:0]        s7_pll_ff, s7_pll_in, s7_phl_ff, s7_phl_in;
   logic signed [51:0] s7_plh_ff, s7_plh_in, s7_phh_ff, s7_phh_in;
   logic signed [46:0] s7_ps_ff;
   logic signed [15:0] s7_temp_ff;
   logic               s7_tclip_ff;

   assign a_lo      = s6_acoef_ff[27:0];
   assign a_hi      = s6_acoef_ff[55:28];
   assign b_lo      = s6_b_ff[23:0];
   assign b_hi      = s6_b_ff[46:24];
   assign s7_pll_in = a_lo * b_lo;
   assign s7_phl_in = a_hi * b_lo;
   assign s7_plh_in = $signed({1'b0, a_lo}) * $signed(b_hi);
   assign s7_phh_in = $signed({1'b0, a_hi}) * $signed(b_hi);

   // ---------------- stage 8: pairwise sums ----------------
   logic signed [103:0] s8_sum0_ff, s8_sum0_in, s8_sum1_ff, s8_sum1_in;
   logic signed [46:0]  s8_ps_ff;
   logic signed [15:0]  s8_temp_ff;
   logic                s8_tclip_ff;

   assign s8_sum0_in = 104'(s7_pll_ff) + 104'({s7_phl_ff, 28'd0});
   assign s8_sum1_in = (104'(s7_phh_ff) <<< 52) + (104'(s7_plh_ff) <<< 24);

   // ---------------- stage 9: full product ----------------
   logic signed [103:0] s9_prod_ff, s9_prod_in;
   logic signed [46:0]  s9_ps_ff;
   logic signed [15:0]  s9_temp_ff;
   logic                s9_tclip_ff;

   assign s9_prod_in = s8_sum0_ff + s8_sum1_ff;

   // ---------------- stage 10: pressure result ----------------
   logic signed [103:0] pnum, pq;
   logic signed [18:0]  pres_sat;
   logic                pclip;
   logic signed [15:0]  s10_temp_ff;
   logic signed [18:0]  s10_pres_ff;
   logic                s10_clip_ff;

   assign pnum = $signed({s9_ps_ff, 54'd0}) - s9_prod_ff;
   assign pq   = pnum >>> ptc_pkg::PRES_SHIFT;

   always_comb begin
      priority if (pq < ptc_pkg::PRES_MIN) begin
         pres_sat = 19'(ptc_pkg::PRES_MIN);
         pclip    = 1'b1;
      end else if (pq > ptc_pkg::PRES_MAX) begin
         pres_sat = 19'(ptc_pkg::PRES_MAX);
         pclip    = 1'b1;
      end else begin
         pres_sat = pq[18:0];
         pclip    = 1'b0;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      s1_dt_ff    <= s1_dt_in;
      s1_d1m_ff   <= s1_d1m_in;

      s2_offs_ff  <= s2_offs_in;
      s2_sens_ff  <= s2_sens_in;
      s2_ts_ff    <= s2_ts_in;
      s2_d1m_ff   <= s1_d1m_ff;

      s3_xprod_ff <= s3_xprod_in;
      s3_offs_ff  <= s2_offs_ff;
      s3_ts_ff    <= s2_ts_ff;
      s3_mag_ff   <= s3_mag_in;
      s3_cold_ff  <= cold;
      s3_hot_ff   <= hot;

      s4_xs_ff    <= s4_xs_in;
      s4_sq_ff    <= s4_sq_in;
      s4_ts_ff    <= s3_ts_ff;
      s4_cold_ff  <= s3_cold_ff;
      s4_hot_ff   <= s3_hot_ff;

      s5_ps_ff    <= s5_ps_in;
      s5_t2_ff    <= s5_t2_in;
      s5_ts_ff    <= s4_ts_ff;
      s5_cold_ff  <= s4_cold_ff;

      s6_temp_ff  <= s6_temp_in;
      s6_tclip_ff <= s6_tclip_in;
      s6_b_ff     <= s6_b_in;
      s6_ps_ff    <= s5_ps_ff;
      s6_acoef_ff <= s6_acoef_in;

      s7_pll_ff   <= s7_pll_in;
      s7_phl_ff   <= s7_phl_in;
      s7_plh_ff   <= s7_plh_in;
      s7_phh_ff   <= s7_phh_in;
      s7_ps_ff    <= s6_ps_ff;
      s7_temp_ff  <= s6_temp_ff;
      s7_tclip_ff <= s6_tclip_ff;

      s8_sum0_ff  <= s8_sum0_in;
      s8_sum1_ff  <= s8_sum1_in;
      s8_ps_ff    <= s7_ps_ff;
      s8_temp_ff  <= s7_temp_ff;
      s8_tclip_ff <= s7_tclip_ff;

      s9_prod_ff  <= s9_prod_in;
      s9_ps_ff    <= s8_ps_ff;
      s9_temp_ff  <= s8_temp_ff;
      s9_tclip_ff <= s8_tclip_ff;

      s10_temp_ff <= s9_temp_ff;
      s10_pres_ff <= pres_sat;
      s10_clip_ff <= s9_tclip_ff | pclip;
   end

   assign rsp_valid           = vld_ff[ptc_pkg::PIPE_DEPTH-1];
   assign rsp_temperature_out = s10_temp_ff;
   assign rsp_pressure_out    = s10_pres_ff;
   assign rsp_clipped         = s10_clip_ff;

   // ---------------- assertions ----------------
   `PTC_ASSERT_NEXT(a_fixed_latency, start && !busy, ##(ptc_pkg::PIPE_DEPTH - 1) rsp_valid, "beat not delivered after pipeline latency")
   `PTC_ASSERT_IMPLY(a_clip_at_limit, rsp_valid && rsp_clipped, rsp_temperature_out == 16'sh7FFF || rsp_temperature_out == 16'sh8000 || rsp_pressure_out == 19'sh3FFFF || rsp_pressure_out == 19'sh40000, "clip flag without a saturated output")

endmodule

`default_nettype wire

>>> verif/tb_pressure_temperature_compensation.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pressure/temperature compensation pipeline.
module tb_pressure_temperature_compensation;

   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 200;
   localparam ptc_pkg::csr_idx_type FIRST_UNMAPPED =
      ptc_pkg::csr_idx_type'(ptc_pkg::CSR_CAL_WORD_FOUR + 1);
   localparam ptc_pkg::csr_idx_type LAST_UNMAPPED  = '1;

   typedef logic signed [159:0] wide_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic signed [18:0] pres;
      logic               clip;
   } reading_type;

   typedef struct packed {
      logic                 is_write;
      ptc_pkg::csr_idx_type index;
      logic [15:0]          wdata;
      logic [15:0]          raw_p;
      logic [15:0]          raw_t;
      logic                 typed;
      reading_type          want;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [15:0]          req_raw_pressure = '0;
   logic [15:0]          req_raw_temperature = '0;
   logic                 rsp_valid;
   logic signed [15:0]   rsp_temperature_out;
   logic signed [18:0]   rsp_pressure_out;
   logic                 rsp_clipped;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   ptc_pkg::csr_idx_type csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   logic [15:0] cal_word [4] = '{16'h0, 16'h0, 16'h0, 16'h0};
   reading_type pending_results [$];
   int          fault_count = 0;
   bit          no_idle = 1'b0;

   pressure_temperature_compensation dut (.*);

   always #1 clock = ~clock;

   // exact compensation: every scaled intermediate kept as a wide integer
   function automatic reading_type compensate(input logic [15:0] p_raw,
                                              input logic [15:0] t_raw);
      wide_type c1, c2, c3, c4, c5, c6, d1, d2;
      wide_type dt, off_s, sens_s, x_s, p_s, t_s, t_num, p_coef, p_num, t_fix, p_fix;
      reading_type r;
      c1 = cal_word[0][15:1];
      c2 = {cal_word[2][5:0], cal_word[3][5:0]};
      c3 = cal_word[3][15:6];
      c4 = cal_word[2][15:6];
      c5 = {cal_word[0][0], cal_word[1][15:6]};
      c6 = cal_word[1][5:0];
      d1 = p_raw;
      d2 = t_raw;
      dt = d2 - (8 * c5 + 20224);
      off_s = c2 * 16384 + (c4 - 512) * dt;              // off * 2^12
      sens_s = (24576 + c1) * 1024 + c3 * dt;            // sens * 2^10
      x_s = sens_s * (d1 - 7168) - off_s * 4096;         // x * 2^24
      p_s = ptc_pkg::PS_BASE + 10 * x_s;                 // press * 2^29
      t_s = 204800 + dt * (c6 + 50);                     // temp * 2^10
      t_num = t_s <<< 30;
      p_coef = 0;
      if (t_s < ptc_pkg::TS_COLD) begin
         t_num = t_num - 11 * (c6 + 24) * (ptc_pkg::TS_COLD - t_s) * (ptc_pkg::TS_COLD - t_s);
         p_coef = 33 * (c6 + 24) * (ptc_pkg::TS_COLD - t_s) * (ptc_pkg::TS_COLD - t_s);
      end else if (t_s > ptc_pkg::TS_HOT) begin
         t_num = t_num - 3 * (c6 + 24) * (t_s - ptc_pkg::TS_HOT) * (t_s - ptc_pkg::TS_HOT);
      end
      // pressure over 2^83
      p_num = (p_s <<< 54) - p_coef * (p_s - ptc_pkg::PS_REF);
      t_fix = t_num >>> ptc_pkg::TEMP_SHIFT;
      p_fix = p_num >>> ptc_pkg::PRES_SHIFT;
      r.clip = 1'b0;
      if (t_fix < ptc_pkg::TEMP_MIN) begin
         r.temp = 16'(ptc_pkg::TEMP_MIN);
         r.clip = 1'b1;
      end else if (t_fix > ptc_pkg::TEMP_MAX) begin
         r.temp = 16'(ptc_pkg::TEMP_MAX);
         r.clip = 1'b1;
      end else begin
         r.temp = t_fix[15:0];
      end
      if (p_fix < ptc_pkg::PRES_MIN) begin
         r.pres = 19'(ptc_pkg::PRES_MIN);
         r.clip = 1'b1;
      end else if (p_fix > ptc_pkg::PRES_MAX) begin
         r.pres = 19'(ptc_pkg::PRES_MAX);
         r.clip = 1'b1;
      end else begin
         r.pres = p_fix[18:0];
      end
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic step_type conv_step(input logic [15:0] p_raw, input logic [15:0] t_raw);
      step_type s;
      s = '0;
      s.raw_p = p_raw;
      s.raw_t = t_raw;
      return s;
   endfunction

   function automatic step_type typed_step(input logic [15:0] p_raw, input logic [15:0] t_raw,
                                           input reading_type want);
      step_type s;
      s = conv_step(p_raw, t_raw);
      s.typed = 1'b1;
      s.want = want;
      return s;
   endfunction

   function automatic step_type cal_step(input ptc_pkg::csr_idx_type idx,
                                         input logic [15:0] data);
      step_type s;
      s = '0;
      s.is_write = 1'b1;
      s.index = idx;
      s.wdata = data;
      return s;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endtask

   // drop start and let every pending beat come back
   task automatic quiesce();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_cal(input ptc_pkg::csr_idx_type idx, input logic [15:0] data);
      int gap;
      quiesce();
      gap = idle_gap();
      repeat (gap + 1) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= ptc_pkg::CSR_CAL_WORD_FOUR) cal_word[idx] = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // start stays high on return so back-to-back beats need no gap
   task automatic send_conversion(input logic [15:0] p_raw, input logic [15:0] t_raw,
                                  input logic typed, input reading_type want);
      int gap;
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_raw_pressure = p_raw;
      req_raw_temperature = t_raw;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? want : compensate(p_raw, t_raw));
   endtask

   always @(posedge clock) begin
      reading_type got, exp_r;
      if (!reset && rsp_valid) begin
         got = reading_type'{rsp_temperature_out, rsp_pressure_out, rsp_clipped};
         if (pending_results.size() == 0) begin
            note_fault($sformatf("unexpected beat: temp %0d pres %0d clip %0b",
                                 got.temp, got.pres, got.clip));
         end else begin
            exp_r = pending_results.pop_front();
            if (got.temp !== exp_r.temp || got.pres !== exp_r.pres || got.clip !== exp_r.clip)
               note_fault($sformatf("exp temp %0d pres %0d clip %0b, got temp %0d pres %0d clip %0b",
                                    exp_r.temp, exp_r.pres, exp_r.clip,
                                    got.temp, got.pres, got.clip));
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb_pressure_temperature_compensation: done, errors");
      $finish;
   end

   initial begin
      step_type    plan [$];
      logic [15:0] words [4];
      logic [15:0] p_raw, t_raw;
      int          cold_t, hot_dt, sel;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      plan = {
         // calibration all zero after reset
         typed_step(16'd7168, 16'd20224, reading_type'{16'sd3200, 19'sd40000, 1'b0}),
         typed_step(16'hFFFF, 16'hFFFF, reading_type'{16'sh7FFF, 19'sh3FFFF, 1'b1}),
         conv_step(16'h0000, 16'h0000),
         conv_step(16'hFFFF, 16'h0000),
         conv_step(16'h0000, 16'hFFFF),
         cal_step(ptc_pkg::CSR_CAL_WORD_ONE, 16'hFFFF),
         cal_step(ptc_pkg::CSR_CAL_WORD_TWO, 16'hFFFF),
         cal_step(ptc_pkg::CSR_CAL_WORD_THREE, 16'hFFFF),
         cal_step(ptc_pkg::CSR_CAL_WORD_FOUR, 16'hFFFF),
         cal_step(FIRST_UNMAPPED, 16'h0000),
         conv_step(16'h0000, 16'h0000),
         conv_step(16'hFFFF, 16'hFFFF),
         conv_step(16'h8000, 16'h8000),
         conv_step(16'd7168, 16'd36600),
         // C6 = 14, so the hot threshold sits exactly 4000 counts above the cold one
         cal_step(ptc_pkg::CSR_CAL_WORD_ONE, 16'hB75A),
         cal_step(ptc_pkg::CSR_CAL_WORD_TWO, 16'h9C0E),
         cal_step(ptc_pkg::CSR_CAL_WORD_THREE, 16'hA2C8),
         cal_step(ptc_pkg::CSR_CAL_WORD_FOUR, 16'hB3D1),
         cal_step(LAST_UNMAPPED, 16'hFFFF),
         conv_step(16'd40000, 16'd25216),
         conv_step(16'd40000, 16'd25215),
         conv_step(16'd40000, 16'd29216),
         conv_step(16'd40000, 16'd29217),
         conv_step(16'd40000, 16'd29215),
         conv_step(16'd20000, 16'd10000),
         conv_step(16'd60000, 16'd50000),
         conv_step(16'd1, 16'd1),
         conv_step(16'hAAAA, 16'h5555),
         conv_step(16'h5555, 16'hAAAA)
      };

      foreach (plan[i]) begin
         if (plan[i].is_write) write_cal(plan[i].index, plan[i].wdata);
         else send_conversion(plan[i].raw_p, plan[i].raw_t, plan[i].typed, plan[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         for (int w = 0; w < 4; w++) begin
            unique case (ph)
               2: words[w] = 16'hFFFF;
               5: words[w] = (w % 2 == 1) ? 16'hFFFF : 16'h0000;
               default: words[w] = 16'($urandom);
            endcase
         end
         if ($urandom_range(0, 1) == 1)
            write_cal(ptc_pkg::csr_idx_type'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED)),
                      16'($urandom));
         write_cal(ptc_pkg::CSR_CAL_WORD_ONE, words[0]);
         write_cal(ptc_pkg::CSR_CAL_WORD_TWO, words[1]);
         write_cal(ptc_pkg::CSR_CAL_WORD_THREE, words[2]);
         write_cal(ptc_pkg::CSR_CAL_WORD_FOUR, words[3]);
         if ($urandom_range(0, 1) == 1)
            write_cal(ptc_pkg::csr_idx_type'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED)),
                      16'($urandom));

         // raw temperature giving dt = 0, and the dt that lands near the hot threshold
         cold_t = 8 * {cal_word[0][0], cal_word[1][15:6]} + 20224;
         hot_dt = 256000 / (cal_word[1][5:0] + 50);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            p_raw = 16'($urandom);
            t_raw = 16'($urandom);
            sel = $urandom_range(0, 9);
            unique case (sel)
               5: t_raw = 16'(cold_t + $urandom_range(0, 4) - 2);
               6: t_raw = 16'(cold_t + hot_dt + $urandom_range(0, 4) - 2);
               7: t_raw = 16'(cold_t + $urandom_range(0, 600) - 300);
               8: begin
                  p_raw = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                  t_raw = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
               end
               9: p_raw = 16'($urandom_range(5000, 12000));
               default: ;
            endcase
            send_conversion(p_raw, t_raw, 1'b0, '0);
         end
      end

      quiesce();
      repeat (2 * ptc_pkg::PIPE_DEPTH) @(posedge clock);
      if (fault_count == 0) $display("tb_pressure_temperature_compensation: done, clean");
      else $display("tb_pressure_temperature_compensation: done, errors");
      $finish;
   end

endmodule
